>>> src/sensor_filter_zone_classifier_defines.svh
// Assertion macros shared by the checker
`ifndef SENSOR_FILTER_ZONE_CLASSIFIER_DEFINES_SVH
`define SENSOR_FILTER_ZONE_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SFZC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SFZC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/sfzc_pkg.sv
package sfzc_pkg;

	// sample and moving average
	localparam int unsigned SAMPLE_W   = 12;
	localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;
	localparam int unsigned WINDOW     = 5;
	localparam int unsigned POS_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned SUM_W      = $clog2(WINDOW * SAMPLE_MAX + 1);
	localparam int unsigned WIN_LOG    = $clog2(WINDOW);
	// floor(s / WINDOW) = (s * AVG_RECIP) >> AVG_SH for every s below 2^SUM_W
	localparam int unsigned AVG_SH      = SUM_W + WIN_LOG;
	localparam int unsigned AVG_RECIP_W = SUM_W + 1;
	localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
		AVG_RECIP_W'(((64'd1 << AVG_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
	localparam int unsigned AVG_PROD_W  = SUM_W + AVG_RECIP_W;

	// exponential average, Q12.16
	localparam int unsigned ALPHA_W = 16;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned EMA_W   = SAMPLE_W + FRAC_W;
	localparam logic [FRAC_W:0] ONE_Q = (FRAC_W + 1)'(1) << FRAC_W;
	localparam int unsigned PA_W    = ALPHA_W + SAMPLE_W;
	localparam int unsigned PB_W    = FRAC_W + 1 + EMA_W;
	localparam int unsigned ACC_W   = PB_W;

	// conversion to hundredths of a degree
	localparam int unsigned CDEG_W    = 16;
	localparam int unsigned CDEG_FULL = 50000;
	localparam int unsigned ADC_FULL  = 4095;
	localparam int unsigned CPROD_W   = EMA_W + CDEG_W;
	localparam int unsigned T_W       = CPROD_W - FRAC_W;
	localparam int unsigned DIV_LOG   = $clog2(ADC_FULL);
	// floor(t / ADC_FULL) = (t * TEMP_RECIP) >> TEMP_SH for every t below 2^T_W
	localparam int unsigned TEMP_SH      = T_W + DIV_LOG;
	localparam int unsigned TEMP_RECIP_W = T_W + 1;
	localparam logic [TEMP_RECIP_W-1:0] TEMP_RECIP =
		TEMP_RECIP_W'(((64'd1 << TEMP_SH) + 64'(ADC_FULL) - 64'd1) / 64'(ADC_FULL));
	localparam int unsigned DPROD_W = T_W + TEMP_RECIP_W;

	localparam int unsigned ANGLE_W = 8;

	// register file
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned IDX_W  = ADDR_W - 2;

	typedef enum logic [IDX_W-1:0] {
		REG_ALPHA      = 3'd0,
		REG_LOW_TH     = 3'd1,
		REG_HIGH_TH    = 3'd2,
		REG_ANG_GREEN  = 3'd3,
		REG_ANG_ORANGE = 3'd4,
		REG_ANG_RED    = 3'd5
	} reg_idx_t;

	localparam logic [ALPHA_W-1:0] ALPHA_RST      = 16'd5898;
	localparam logic [CDEG_W-1:0]  LOW_TH_RST     = 16'd1000;
	localparam logic [CDEG_W-1:0]  HIGH_TH_RST    = 16'd1350;
	localparam logic [ANGLE_W-1:0] ANG_GREEN_RST  = 8'd30;
	localparam logic [ANGLE_W-1:0] ANG_ORANGE_RST = 8'd90;
	localparam logic [ANGLE_W-1:0] ANG_RED_RST    = 8'd150;

	typedef enum logic [1:0] {
		ZONE_GREEN  = 2'd0,
		ZONE_ORANGE = 2'd1,
		ZONE_RED    = 2'd2
	} zone_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic [CDEG_W-1:0]  low_th;
		logic [CDEG_W-1:0]  high_th;
		logic [ANGLE_W-1:0] ang_green;
		logic [ANGLE_W-1:0] ang_orange;
		logic [ANGLE_W-1:0] ang_red;
	} cfg_t;

	// sequencer commands to the datapath
	typedef struct packed {
		logic take;     // word accepted: ring update, EMA products
		logic ld_acc;   // new EMA, average product
		logic ld_conv;  // EMA scaled to cdeg * 4095
		logic ld_div;   // reciprocal product for /4095
		logic ld_out;   // classify and load output register
	} dp_cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ACC  = 5'b00010,
		ST_CONV = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

endpackage

>>> src/sfzc_regs.sv
module sfzc_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sfzc_pkg::ADDR_W-1:0]      paddr,
	input  logic [sfzc_pkg::DATA_W-1:0]      pwdata,
	output logic [sfzc_pkg::DATA_W-1:0]      prdata,
	output logic                             pready,
	output sfzc_pkg::cfg_t                   cfg
);

	sfzc_pkg::cfg_t cfg_q;
	logic [sfzc_pkg::IDX_W-1:0] idx;
	logic wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[sfzc_pkg::ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha      <= sfzc_pkg::ALPHA_RST;
			cfg_q.low_th     <= sfzc_pkg::LOW_TH_RST;
			cfg_q.high_th    <= sfzc_pkg::HIGH_TH_RST;
			cfg_q.ang_green  <= sfzc_pkg::ANG_GREEN_RST;
			cfg_q.ang_orange <= sfzc_pkg::ANG_ORANGE_RST;
			cfg_q.ang_red    <= sfzc_pkg::ANG_RED_RST;
		end else if (wr_en) begin
			case (idx)
				sfzc_pkg::REG_ALPHA:      cfg_q.alpha      <= pwdata[sfzc_pkg::ALPHA_W-1:0];
				sfzc_pkg::REG_LOW_TH:     cfg_q.low_th     <= pwdata[sfzc_pkg::CDEG_W-1:0];
				sfzc_pkg::REG_HIGH_TH:    cfg_q.high_th    <= pwdata[sfzc_pkg::CDEG_W-1:0];
				sfzc_pkg::REG_ANG_GREEN:  cfg_q.ang_green  <= pwdata[sfzc_pkg::ANGLE_W-1:0];
				sfzc_pkg::REG_ANG_ORANGE: cfg_q.ang_orange <= pwdata[sfzc_pkg::ANGLE_W-1:0];
				sfzc_pkg::REG_ANG_RED:    cfg_q.ang_red    <= pwdata[sfzc_pkg::ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			sfzc_pkg::REG_ALPHA:      prdata = sfzc_pkg::DATA_W'(cfg_q.alpha);
			sfzc_pkg::REG_LOW_TH:     prdata = sfzc_pkg::DATA_W'(cfg_q.low_th);
			sfzc_pkg::REG_HIGH_TH:    prdata = sfzc_pkg::DATA_W'(cfg_q.high_th);
			sfzc_pkg::REG_ANG_GREEN:  prdata = sfzc_pkg::DATA_W'(cfg_q.ang_green);
			sfzc_pkg::REG_ANG_ORANGE: prdata = sfzc_pkg::DATA_W'(cfg_q.ang_orange);
			sfzc_pkg::REG_ANG_RED:    prdata = sfzc_pkg::DATA_W'(cfg_q.ang_red);
			default:                  prdata = '0;
		endcase
	end

endmodule

>>> src/sfzc_ctrl.sv
module sfzc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output sfzc_pkg::dp_cmd_t   cmd
);

	sfzc_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	// output slot free now, or emptied at this edge
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != sfzc_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	assign cmd.take    = in_valid && (state_q == sfzc_pkg::ST_IDLE);
	assign cmd.ld_acc  = (state_q == sfzc_pkg::ST_ACC);
	assign cmd.ld_conv = (state_q == sfzc_pkg::ST_CONV);
	assign cmd.ld_div  = (state_q == sfzc_pkg::ST_DIV);
	assign cmd.ld_out  = (state_q == sfzc_pkg::ST_FIN) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			sfzc_pkg::ST_IDLE: if (in_valid) state_d = sfzc_pkg::ST_ACC;
			sfzc_pkg::ST_ACC:  state_d = sfzc_pkg::ST_CONV;
			sfzc_pkg::ST_CONV: state_d = sfzc_pkg::ST_DIV;
			sfzc_pkg::ST_DIV:  state_d = sfzc_pkg::ST_FIN;
			sfzc_pkg::ST_FIN:  if (out_free) state_d = sfzc_pkg::ST_IDLE;
			default:           state_d = sfzc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sfzc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/sfzc_dp.sv
module sfzc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sfzc_pkg::dp_cmd_t                   cmd,
	input  sfzc_pkg::cfg_t                      cfg,
	input  logic [sfzc_pkg::SAMPLE_W-1:0]       sample,
	output logic [sfzc_pkg::SAMPLE_W-1:0]       window_average,
	output logic [sfzc_pkg::SAMPLE_W-1:0]       smoothed_value,
	output logic [sfzc_pkg::CDEG_W-1:0]         temperature_cdeg,
	output logic [1:0]                          zone,
	output logic [sfzc_pkg::ANGLE_W-1:0]        servo_angle
);

	// architectural state
	logic [sfzc_pkg::SAMPLE_W-1:0] ring_q [sfzc_pkg::WINDOW];
	logic [sfzc_pkg::POS_W-1:0]    pos_q;
	logic [sfzc_pkg::SUM_W-1:0]    sum_q;
	logic [sfzc_pkg::EMA_W-1:0]    ema_q;

	// intermediate products
	logic [sfzc_pkg::PA_W-1:0]       pa_q;
	logic [sfzc_pkg::PB_W-1:0]       pb_q;
	logic [sfzc_pkg::AVG_PROD_W-1:0] avg_prod_q;
	logic [sfzc_pkg::T_W-1:0]        t_q;
	logic [sfzc_pkg::DPROD_W-1:0]    dprod_q;

	// output register
	logic [sfzc_pkg::SAMPLE_W-1:0] avg_out_q;
	logic [sfzc_pkg::SAMPLE_W-1:0] ema_out_q;
	logic [sfzc_pkg::CDEG_W-1:0]   temp_out_q;
	sfzc_pkg::zone_t               zone_out_q;
	logic [sfzc_pkg::ANGLE_W-1:0]  angle_out_q;

	logic [sfzc_pkg::FRAC_W:0]      one_minus_a;
	logic [sfzc_pkg::ACC_W-1:0]     acc;
	logic [sfzc_pkg::CPROD_W-1:0]   cprod;
	logic [sfzc_pkg::CDEG_W-1:0]    temp;
	sfzc_pkg::zone_t                zone_d;
	logic [sfzc_pkg::ANGLE_W-1:0]   angle_d;

	assign one_minus_a = sfzc_pkg::ONE_Q - (sfzc_pkg::FRAC_W + 1)'(cfg.alpha);
	assign acc = sfzc_pkg::ACC_W'({pa_q, {sfzc_pkg::FRAC_W{1'b0}}}) + pb_q;
	assign cprod = sfzc_pkg::CPROD_W'(ema_q) * sfzc_pkg::CPROD_W'(sfzc_pkg::CDEG_FULL);
	assign temp = dprod_q[sfzc_pkg::TEMP_SH +: sfzc_pkg::CDEG_W];

	// red is tested first, so it wins over inverted thresholds
	always_comb begin
		if (temp >= cfg.high_th) begin
			zone_d  = sfzc_pkg::ZONE_RED;
			angle_d = cfg.ang_red;
		end else if (temp < cfg.low_th) begin
			zone_d  = sfzc_pkg::ZONE_GREEN;
			angle_d = cfg.ang_green;
		end else begin
			zone_d  = sfzc_pkg::ZONE_ORANGE;
			angle_d = cfg.ang_orange;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sfzc_pkg::WINDOW; i++) begin
				ring_q[i] <= '0;
			end
			pos_q <= '0;
			sum_q <= '0;
			ema_q <= '0;
		end else begin
			if (cmd.take) begin
				sum_q <= sum_q - sfzc_pkg::SUM_W'(ring_q[pos_q])
					+ sfzc_pkg::SUM_W'(sample);
				ring_q[pos_q] <= sample;
				if (pos_q == sfzc_pkg::POS_W'(sfzc_pkg::WINDOW - 1)) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + sfzc_pkg::POS_W'(1);
				end
			end
			if (cmd.ld_acc) begin
				ema_q <= acc[sfzc_pkg::FRAC_W +: sfzc_pkg::EMA_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pa_q <= sfzc_pkg::PA_W'(cfg.alpha) * sfzc_pkg::PA_W'(sample);
			pb_q <= sfzc_pkg::PB_W'(one_minus_a) * sfzc_pkg::PB_W'(ema_q);
		end
		if (cmd.ld_acc) begin
			avg_prod_q <= sfzc_pkg::AVG_PROD_W'(sum_q)
				* sfzc_pkg::AVG_PROD_W'(sfzc_pkg::AVG_RECIP);
		end
		if (cmd.ld_conv) begin
			t_q <= cprod[sfzc_pkg::FRAC_W +: sfzc_pkg::T_W];
		end
		if (cmd.ld_div) begin
			dprod_q <= sfzc_pkg::DPROD_W'(t_q) * sfzc_pkg::DPROD_W'(sfzc_pkg::TEMP_RECIP);
		end
		if (cmd.ld_out) begin
			avg_out_q   <= avg_prod_q[sfzc_pkg::AVG_SH +: sfzc_pkg::SAMPLE_W];
			ema_out_q   <= ema_q[sfzc_pkg::FRAC_W +: sfzc_pkg::SAMPLE_W];
			temp_out_q  <= temp;
			zone_out_q  <= zone_d;
			angle_out_q <= angle_d;
		end
	end

	assign window_average   = avg_out_q;
	assign smoothed_value   = ema_out_q;
	assign temperature_cdeg = temp_out_q;
	assign zone             = zone_out_q;
	assign servo_angle      = angle_out_q;

endmodule

>>> src/sensor_filter_zone_classifier.sv
// A word accepted in IDLE passes through ACC, CONV and DIV to FIN, where the output
//   register is loaded and out_valid raised once the output slot is free.
// The five-step sequencer runs the multiply chain (EMA, scale, /4095), busy outside IDLE.
// A new word is taken as soon as the sequencer is idle, even while a result waits.
// Reset (arst_n low, asynchronous): sample ring, running sum, EMA and sequencer clear,
//   output empties, configuration returns to its default values.
module sensor_filter_zone_classifier (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sfzc_pkg::ADDR_W-1:0]      paddr,
	input  logic [sfzc_pkg::DATA_W-1:0]      pwdata,
	output logic [sfzc_pkg::DATA_W-1:0]      prdata,
	output logic                             pready,
	// sample words in
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [sfzc_pkg::SAMPLE_W-1:0]    sample,
	// result words out
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [sfzc_pkg::SAMPLE_W-1:0]    window_average,
	output logic [sfzc_pkg::SAMPLE_W-1:0]    smoothed_value,
	output logic [sfzc_pkg::CDEG_W-1:0]      temperature_cdeg,
	output logic [1:0]                       zone,
	output logic [sfzc_pkg::ANGLE_W-1:0]     servo_angle
);

	// Structure
	//   sfzc_regs : six configuration registers behind the APB-style port.
	//   sfzc_ctrl : one-hot sequencer IDLE -> ACC -> CONV -> DIV -> FIN, plus the
	//               valid bit of the output register.
	//   sfzc_dp   : sample ring, running sum, EMA state and the product registers.
	//
	// Step by step
	//   IDLE : word taken; ring slot swapped into the running sum, both EMA
	//          products (alpha*x and (1-alpha)*old) registered.
	//   ACC  : products summed and shifted into the new Q12.16 EMA; running sum
	//          times the reciprocal of the window length.
	//   CONV : EMA * 50000 >> 16, i.e. hundredths of a degree times 4095.
	//   DIV  : multiply by the reciprocal of 4095 (exact for the whole range).
	//   FIN  : thresholds compared, zone and angle picked, output register loaded;
	//          waits here if the previous result is still stalled.
	// Every multiply lands in a register before anything else uses it.

	sfzc_pkg::cfg_t    cfg;
	sfzc_pkg::dp_cmd_t cmd;

	sfzc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sfzc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	sfzc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg              (cfg),
		.sample           (sample),
		.window_average   (window_average),
		.smoothed_value   (smoothed_value),
		.temperature_cdeg (temperature_cdeg),
		.zone             (zone),
		.servo_angle      (servo_angle)
	);

endmodule

>>> src/sfzc_checker.sv
`include "sensor_filter_zone_classifier_defines.svh"

module sfzc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [sfzc_pkg::SAMPLE_W-1:0]   window_average,
	input logic [sfzc_pkg::SAMPLE_W-1:0]   smoothed_value,
	input logic [sfzc_pkg::CDEG_W-1:0]     temperature_cdeg,
	input logic [1:0]                      zone,
	input logic [sfzc_pkg::ANGLE_W-1:0]    servo_angle
);

	`SFZC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")

	`SFZC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(window_average) && $stable(smoothed_value) && $stable(temperature_cdeg) && $stable(zone) && $stable(servo_angle), "stalled result changed")

	`SFZC_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "second word taken while busy")

	`SFZC_ASSERT_NOW(a_result_range, out_valid, (temperature_cdeg <= sfzc_pkg::CDEG_W'(sfzc_pkg::CDEG_FULL)) && (zone == sfzc_pkg::ZONE_GREEN || zone == sfzc_pkg::ZONE_ORANGE || zone == sfzc_pkg::ZONE_RED), "result out of range")

endmodule

bind sensor_filter_zone_classifier sfzc_checker u_sfzc_checker (.*);

>>> bench/sfzc_filter_checker.sv
module sfzc_filter_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [sfzc_pkg::ADDR_W-1:0]   paddr,
	input  logic [sfzc_pkg::DATA_W-1:0]   pwdata,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [sfzc_pkg::SAMPLE_W-1:0] sample,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [sfzc_pkg::SAMPLE_W-1:0] window_average,
	input  logic [sfzc_pkg::SAMPLE_W-1:0] smoothed_value,
	input  logic [sfzc_pkg::CDEG_W-1:0]   temperature_cdeg,
	input  logic [1:0]                    zone,
	input  logic [sfzc_pkg::ANGLE_W-1:0]  servo_angle,
	output int unsigned                   fail_count,
	output int unsigned                   pending
);

	typedef struct packed {
		logic [sfzc_pkg::SAMPLE_W-1:0] average;
		logic [sfzc_pkg::SAMPLE_W-1:0] smoothed;
		logic [sfzc_pkg::CDEG_W-1:0]   cdeg;
		sfzc_pkg::zone_t               zone;
		logic [sfzc_pkg::ANGLE_W-1:0]  angle;
	} reading_t;

	reading_t expected_readings[$];

	sfzc_pkg::cfg_t                live_cfg;
	logic [sfzc_pkg::SAMPLE_W-1:0] ring [sfzc_pkg::WINDOW];
	logic [sfzc_pkg::POS_W-1:0]    slot;
	logic [sfzc_pkg::SUM_W-1:0]    ring_sum;
	logic [sfzc_pkg::EMA_W-1:0]    ema;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		fail_count++;
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
	endtask

	// ring and EMA update, then window mean, degree conversion and zone pick
	task automatic absorb_sample(input logic [sfzc_pkg::SAMPLE_W-1:0] x);
		logic [63:0] acc;
		logic [63:0] cdeg_full;
		logic [63:0] mean;
		reading_t    r;
		ring_sum = ring_sum - sfzc_pkg::SUM_W'(ring[slot]) + sfzc_pkg::SUM_W'(x);
		ring[slot] = x;
		slot = (slot == sfzc_pkg::POS_W'(sfzc_pkg::WINDOW - 1)) ? '0 :
			slot + sfzc_pkg::POS_W'(1);
		acc = (64'(live_cfg.alpha) * 64'(x)) << sfzc_pkg::FRAC_W;
		acc = acc + (64'(sfzc_pkg::ONE_Q) - 64'(live_cfg.alpha)) * 64'(ema);
		ema = acc[sfzc_pkg::FRAC_W +: sfzc_pkg::EMA_W];
		cdeg_full = (64'(ema) * 64'(sfzc_pkg::CDEG_FULL))
			/ (64'(sfzc_pkg::ADC_FULL) << sfzc_pkg::FRAC_W);
		mean = 64'(ring_sum) / 64'(sfzc_pkg::WINDOW);
		r.average = mean[sfzc_pkg::SAMPLE_W-1:0];
		r.smoothed = ema[sfzc_pkg::FRAC_W +: sfzc_pkg::SAMPLE_W];
		r.cdeg = cdeg_full[sfzc_pkg::CDEG_W-1:0];
		if (cdeg_full >= 64'(live_cfg.high_th)) begin
			r.zone = sfzc_pkg::ZONE_RED;
			r.angle = live_cfg.ang_red;
		end else if (cdeg_full < 64'(live_cfg.low_th)) begin
			r.zone = sfzc_pkg::ZONE_GREEN;
			r.angle = live_cfg.ang_green;
		end else begin
			r.zone = sfzc_pkg::ZONE_ORANGE;
			r.angle = live_cfg.ang_orange;
		end
		expected_readings.push_back(r);
	endtask

	task automatic compare_reading();
		reading_t want;
		if (expected_readings.size() == 0) begin
			report_mismatch("result word with nothing pending", 32'(zone), 32'd0);
			return;
		end
		want = expected_readings.pop_front();
		if (window_average !== want.average)
			report_mismatch("window_average", 32'(window_average), 32'(want.average));
		if (smoothed_value !== want.smoothed)
			report_mismatch("smoothed_value", 32'(smoothed_value), 32'(want.smoothed));
		if (temperature_cdeg !== want.cdeg)
			report_mismatch("temperature_cdeg", 32'(temperature_cdeg), 32'(want.cdeg));
		if (zone !== want.zone)
			report_mismatch("zone", 32'(zone), 32'(want.zone));
		if (servo_angle !== want.angle)
			report_mismatch("servo_angle", 32'(servo_angle), 32'(want.angle));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < sfzc_pkg::WINDOW; k++)
				ring[k] = '0;
			slot = '0;
			ring_sum = '0;
			ema = '0;
			live_cfg.alpha = sfzc_pkg::ALPHA_RST;
			live_cfg.low_th = sfzc_pkg::LOW_TH_RST;
			live_cfg.high_th = sfzc_pkg::HIGH_TH_RST;
			live_cfg.ang_green = sfzc_pkg::ANG_GREEN_RST;
			live_cfg.ang_orange = sfzc_pkg::ANG_ORANGE_RST;
			live_cfg.ang_red = sfzc_pkg::ANG_RED_RST;
			expected_readings.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[sfzc_pkg::ADDR_W-1:2])
					sfzc_pkg::REG_ALPHA:
						live_cfg.alpha = pwdata[sfzc_pkg::ALPHA_W-1:0];
					sfzc_pkg::REG_LOW_TH:
						live_cfg.low_th = pwdata[sfzc_pkg::CDEG_W-1:0];
					sfzc_pkg::REG_HIGH_TH:
						live_cfg.high_th = pwdata[sfzc_pkg::CDEG_W-1:0];
					sfzc_pkg::REG_ANG_GREEN:
						live_cfg.ang_green = pwdata[sfzc_pkg::ANGLE_W-1:0];
					sfzc_pkg::REG_ANG_ORANGE:
						live_cfg.ang_orange = pwdata[sfzc_pkg::ANGLE_W-1:0];
					sfzc_pkg::REG_ANG_RED:
						live_cfg.ang_red = pwdata[sfzc_pkg::ANGLE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				absorb_sample(sample);
			if (out_valid && !out_stall)
				compare_reading();
		end
		pending = expected_readings.size();
	end

endmodule

>>> bench/tb_top.sv
module tb_top;

	// register slot past the last one, must be ignored
	localparam logic [sfzc_pkg::IDX_W-1:0] REG_UNUSED = 3'd6;
	// length of the forced output hold-off, in cycles
	localparam int LONG_HOLD = 300;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [sfzc_pkg::ADDR_W-1:0]    paddr;
	logic [sfzc_pkg::DATA_W-1:0]    pwdata;
	logic [sfzc_pkg::DATA_W-1:0]    prdata;
	logic                           pready;
	logic                           in_valid;
	logic                           in_stall;
	logic [sfzc_pkg::SAMPLE_W-1:0]  sample;
	logic                           out_valid;
	logic                           out_stall;
	logic [sfzc_pkg::SAMPLE_W-1:0]  window_average;
	logic [sfzc_pkg::SAMPLE_W-1:0]  smoothed_value;
	logic [sfzc_pkg::CDEG_W-1:0]    temperature_cdeg;
	logic [1:0]                     zone;
	logic [sfzc_pkg::ANGLE_W-1:0]   servo_angle;

	int unsigned fail_count;
	int unsigned pending;

	// idling switches, flipped between phases by the stimulus
	bit sender_idle_on;
	bit receiver_idle_on;
	// raised by the stimulus, cleared by the receiver once the long hold-off is over
	bit hold_off_req;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	sensor_filter_zone_classifier u_dut (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .sample,
		.out_valid, .out_stall,
		.window_average, .smoothed_value, .temperature_cdeg, .zone, .servo_angle
	);

	sfzc_filter_checker u_checker (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.in_valid, .in_stall, .sample,
		.out_valid, .out_stall,
		.window_average, .smoothed_value, .temperature_cdeg, .zone, .servo_angle,
		.fail_count, .pending
	);

	// hard stop well past the slowest legal run
	initial begin
		#20000000;
		$display("FAILED: results differ");
		$finish;
	end

	// Gap before the next sample word: mostly back to back, some short pauses,
	// now and then a long one.
	function automatic int idle_gap();
		int r;
		if (!sender_idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one word; returns right after the edge that takes it.
	// Valid only drops when a gap is wanted, so it is never lowered and raised
	// within one step.
	task automatic push_sample(input logic [sfzc_pkg::SAMPLE_W-1:0] v);
		int gap;
		gap = idle_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= v;
		do @(posedge clk); while (in_stall);
	endtask

	// Setup then access cycle; pready is tied high so the write lands on the
	// edge after penable rises.
	task automatic write_reg(input logic [sfzc_pkg::IDX_W-1:0] idx,
			input logic [sfzc_pkg::DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes every register; junk in the unused upper bits must be dropped.
	task automatic apply_settings(input logic [sfzc_pkg::ALPHA_W-1:0] alpha,
			input logic [sfzc_pkg::CDEG_W-1:0] low_th,
			input logic [sfzc_pkg::CDEG_W-1:0] high_th,
			input logic [sfzc_pkg::ANGLE_W-1:0] green,
			input logic [sfzc_pkg::ANGLE_W-1:0] orange,
			input logic [sfzc_pkg::ANGLE_W-1:0] red);
		logic [sfzc_pkg::DATA_W-1:0] junk;
		junk = $urandom;
		write_reg(sfzc_pkg::REG_ALPHA, {junk[31:16], alpha});
		write_reg(sfzc_pkg::REG_LOW_TH, {junk[15:0], low_th});
		write_reg(sfzc_pkg::REG_HIGH_TH, {junk[31:16], high_th});
		write_reg(sfzc_pkg::REG_ANG_GREEN, {junk[23:0], green});
		write_reg(sfzc_pkg::REG_ANG_ORANGE, {junk[31:8], orange});
		write_reg(sfzc_pkg::REG_ANG_RED, {junk[27:4], red});
		write_reg(REG_UNUSED, $urandom);
	endtask

	// Drop valid and wait until every word sent has come back out.
	task automatic finish_phase();
		int guard;
		@(negedge clk);
		in_valid <= 1'b0;
		guard = 0;
		while (pending != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	function automatic logic [sfzc_pkg::ANGLE_W-1:0] pick_angle();
		if ($urandom_range(0, 9) == 0)
			return {sfzc_pkg::ANGLE_W{1'b1}};
		return sfzc_pkg::ANGLE_W'($urandom_range(0, 180));
	endfunction

	task automatic pick_settings();
		logic [sfzc_pkg::ALPHA_W-1:0] a;
		logic [sfzc_pkg::CDEG_W-1:0]  lo;
		logic [sfzc_pkg::CDEG_W-1:0]  hi;
		logic [sfzc_pkg::CDEG_W-1:0]  t;
		case ($urandom_range(0, 7))
			0: a = '0;
			1: a = '1;
			2: a = 16'd1;
			3, 4: a = sfzc_pkg::ALPHA_W'($urandom_range(1, 4095));
			default: a = sfzc_pkg::ALPHA_W'($urandom_range(1, 65535));
		endcase
		lo = sfzc_pkg::CDEG_W'($urandom_range(0, sfzc_pkg::CDEG_FULL));
		hi = sfzc_pkg::CDEG_W'($urandom_range(0, sfzc_pkg::CDEG_FULL));
		// mostly ordered thresholds, sometimes crossed
		if ($urandom_range(0, 3) != 0 && lo > hi) begin
			t = lo;
			lo = hi;
			hi = t;
		end
		if ($urandom_range(0, 9) == 0)
			hi = sfzc_pkg::CDEG_W'($urandom_range(sfzc_pkg::CDEG_FULL + 1, 65535));
		apply_settings(a, lo, hi, pick_angle(), pick_angle(), pick_angle());
	endtask

	// Sample source: a drifting level with small noise, mixed with rail values
	// and uniform picks so the EMA settles, climbs and falls through the zones.
	function automatic logic [sfzc_pkg::SAMPLE_W-1:0] wander(input int level);
		int r;
		int v;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return sfzc_pkg::SAMPLE_W'(sfzc_pkg::SAMPLE_MAX);
		if (r < 5)
			return sfzc_pkg::SAMPLE_W'($urandom_range(0, sfzc_pkg::SAMPLE_MAX));
		v = level + int'($urandom_range(0, 64)) - 32;
		if (v < 0)
			v = 0;
		if (v > int'(sfzc_pkg::SAMPLE_MAX))
			v = int'(sfzc_pkg::SAMPLE_MAX);
		return sfzc_pkg::SAMPLE_W'(v);
	endfunction

	task automatic drive_random(input int count, input bit squeeze);
		int level;
		level = 0;
		for (int k = 0; k < count; k++) begin
			if (k % 32 == 0)
				level = $urandom_range(0, sfzc_pkg::SAMPLE_MAX);
			// long output hold-off while words keep coming
			if (squeeze && k == count / 3)
				hold_off_req = 1'b1;
			push_sample(wander(level));
		end
	endtask

	// Receiver: random stall runs, plus the long hold-off on request.
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_off_req = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
			end else if (receiver_idle_on && $urandom_range(0, 99) < 35) begin
				out_stall <= 1'b1;
				stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) :
					$urandom_range(9, 39);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		sample = '0;
		sender_idle_on = 1'b1;
		receiver_idle_on = 1'b1;
		hold_off_req = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Defaults after reset: a full-scale run puts the EMA in red from the first word,
		// then a drop and alternating bit patterns.
		repeat (6) push_sample(sfzc_pkg::SAMPLE_W'(sfzc_pkg::SAMPLE_MAX));
		push_sample('0);
		push_sample(12'hAAA);
		push_sample(12'h555);
		push_sample(12'd1);
		push_sample(12'h800);
		finish_phase();

		// Near-instant EMA; zero reading sits exactly on the low threshold
		// (orange), full scale is at or over the high one (red).
		apply_settings('1, '0, 16'd1, '0, 8'd180, '1);
		repeat (3) push_sample('0);
		repeat (2) push_sample(sfzc_pkg::SAMPLE_W'(sfzc_pkg::SAMPLE_MAX));
		finish_phase();

		// Alpha of zero: EMA frozen whatever comes in.
		apply_settings('0, sfzc_pkg::CDEG_W'(sfzc_pkg::CDEG_FULL), '1, 8'd180, '0, '0);
		push_sample('0);
		push_sample(sfzc_pkg::SAMPLE_W'(sfzc_pkg::SAMPLE_MAX));
		finish_phase();

		// Crossed thresholds: red must win over green.
		apply_settings('1, sfzc_pkg::CDEG_W'(sfzc_pkg::CDEG_FULL), 16'd1000,
			8'd1, 8'd2, 8'd3);
		push_sample('0);
		push_sample(sfzc_pkg::SAMPLE_W'(sfzc_pkg::SAMPLE_MAX));
		finish_phase();

		// Thresholds out of reach: always green; slowest possible EMA.
		apply_settings(16'd1, '1, '1, 8'd45, 8'd46, 8'd47);
		push_sample(sfzc_pkg::SAMPLE_W'(sfzc_pkg::SAMPLE_MAX));
		push_sample(12'h800);
		finish_phase();

		// Random phases, fresh settings each time. Phase 1 runs flat out on
		// both sides; phase 3 holds the output off for a long stretch while
		// the sender keeps pushing.
		for (int ph = 0; ph < 7; ph++) begin
			pick_settings();
			sender_idle_on = (ph != 1 && ph != 3);
			receiver_idle_on = (ph != 1 && ph != 5);
			drive_random(250, ph == 3);
			finish_phase();
		end

		repeat (12) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
